// ----- hdl/snpl_pkg.sv -----
package snpl_pkg;

	// Default list depth.
	localparam int SNPL_DEPTH = 16;

	// Field widths fixed by the stream format.
	localparam int ADDR_W  = 32;
	localparam int PREF_W  = 16;
	localparam int POS_W   = 5;
	localparam int COUNT_W = 5;

	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_POP    = 3'd1,
		OP_READ   = 3'd2,
		OP_MEMBER = 3'd3,
		OP_CLEAR  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_INS_PUT,
		S_POP_HEAD,
		S_POP_SHIFT,
		S_READ,
		S_MEMBER,
		S_FINISH
	} seq_state_t;

	// One stored list entry.
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [PREF_W-1:0] pref;
	} entry_t;

	// One incoming request, unpacked.
	typedef struct packed {
		logic [2:0]        op;
		logic [ADDR_W-1:0] hop_address;
		logic [PREF_W-1:0] preference;
		logic [POS_W-1:0]  position;
	} req_t;

	// Result of one request, without the entry count.
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [PREF_W-1:0] pref;
		logic              present;
		status_t           status;
	} res_t;

endpackage

// ----- hdl/snpl_mem.sv -----
module snpl_mem import snpl_pkg::*; #(
	parameter int DEPTH = SNPL_DEPTH
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  entry_t                                 wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output entry_t                                 rdata
);

	// Entry store: one write port, one read port, registered read data.
	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/snpl_seq.sv -----
module snpl_seq import snpl_pkg::*; #(
	parameter int DEPTH = SNPL_DEPTH,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  req_t                req,
	output logic                req_ready,
	output logic                res_valid,
	output res_t                res,
	output logic [COUNT_W-1:0]  count,
	input  logic                res_free,
	output logic                mem_we,
	output logic [AW-1:0]       mem_waddr,
	output entry_t              mem_wdata,
	output logic [AW-1:0]       mem_raddr,
	input  entry_t              mem_rdata
);

	localparam int PW = (CW > POS_W) ? CW : POS_W;

	seq_state_t        state_q, state_d;
	logic [CW-1:0]     occ_q, occ_d;
	logic [AW-1:0]     k_q, k_d;
	logic [ADDR_W-1:0] hop_q, hop_d;
	logic [PREF_W-1:0] pref_q, pref_d;
	res_t              res_q, res_d;
	logic [PW-1:0]     pos_w, occ_w, idx_w;
	logic              k_is_last;

	// Clamp of a read position to the range 1 .. occupancy.
	always_comb begin
		pos_w = PW'(req.position);
		occ_w = PW'(occ_q);
		idx_w = (pos_w == '0) ? PW'(1) : pos_w;
		if (idx_w > occ_w) begin
			idx_w = occ_w;
		end
	end

	assign k_is_last = ((CW'(k_q) + CW'(1)) == occ_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q   <= '0;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_d;
		end
	end

	always_ff @(posedge clk) begin
		k_q    <= k_d;
		hop_q  <= hop_d;
		pref_q <= pref_d;
		res_q  <= res_d;
	end

	always_comb begin
		state_d   = state_q;
		occ_d     = occ_q;
		k_d       = k_q;
		hop_d     = hop_q;
		pref_d    = pref_q;
		res_d     = res_q;
		mem_we    = 1'b0;
		mem_waddr = k_q;
		mem_wdata = '{addr: hop_q, pref: pref_q};
		mem_raddr = '0;
		req_ready = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					hop_d  = req.hop_address;
					pref_d = req.preference;
					res_d  = '{addr: '0, pref: '0, present: 1'b0, status: STAT_OK};
					state_d = S_FINISH;
					case (req.op)
						OP_INSERT: begin
							if (occ_q == CW'(DEPTH)) begin
								res_d.status = STAT_FULL;
							end else if (occ_q == '0) begin
								mem_we    = 1'b1;
								mem_waddr = '0;
								mem_wdata = '{addr: req.hop_address, pref: req.preference};
								occ_d     = occ_q + CW'(1);
							end else begin
								mem_raddr = AW'(occ_q - CW'(1));
								k_d       = AW'(occ_q);
								state_d   = S_INS;
							end
						end
						OP_POP: begin
							if (occ_q == '0) begin
								res_d.status = STAT_EMPTY;
							end else begin
								mem_raddr = '0;
								state_d   = S_POP_HEAD;
							end
						end
						OP_READ: begin
							if (occ_q == '0) begin
								res_d.status = STAT_EMPTY;
							end else begin
								mem_raddr = AW'(idx_w - PW'(1));
								state_d   = S_READ;
							end
						end
						OP_MEMBER: begin
							if (occ_q != '0) begin
								mem_raddr = '0;
								k_d       = '0;
								state_d   = S_MEMBER;
							end
						end
						OP_CLEAR: begin
							occ_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			S_INS: begin
				// Walk down from the tail, moving larger entries up by one.
				mem_we    = 1'b1;
				mem_waddr = k_q;
				if (mem_rdata.pref > pref_q) begin
					mem_wdata = mem_rdata;
					if (k_q == AW'(1)) begin
						k_d     = '0;
						state_d = S_INS_PUT;
					end else begin
						mem_raddr = AW'(k_q - AW'(2));
						k_d       = k_q - AW'(1);
					end
				end else begin
					occ_d   = occ_q + CW'(1);
					state_d = S_FINISH;
				end
			end
			S_INS_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
				occ_d     = occ_q + CW'(1);
				state_d   = S_FINISH;
			end
			S_POP_HEAD: begin
				res_d.addr = mem_rdata.addr;
				res_d.pref = mem_rdata.pref;
				if (occ_q == CW'(1)) begin
					occ_d   = occ_q - CW'(1);
					state_d = S_FINISH;
				end else begin
					mem_raddr = AW'(1);
					k_d       = AW'(1);
					state_d   = S_POP_SHIFT;
				end
			end
			S_POP_SHIFT: begin
				mem_we    = 1'b1;
				mem_waddr = k_q - AW'(1);
				mem_wdata = mem_rdata;
				if (k_is_last) begin
					occ_d   = occ_q - CW'(1);
					state_d = S_FINISH;
				end else begin
					mem_raddr = k_q + AW'(1);
					k_d       = k_q + AW'(1);
				end
			end
			S_READ: begin
				res_d.addr = mem_rdata.addr;
				res_d.pref = mem_rdata.pref;
				state_d    = S_FINISH;
			end
			S_MEMBER: begin
				if (mem_rdata.addr == hop_q) begin
					res_d.present = 1'b1;
				end
				if (k_is_last) begin
					state_d = S_FINISH;
				end else begin
					mem_raddr = k_q + AW'(1);
					k_d       = k_q + AW'(1);
				end
			end
			S_FINISH: begin
				res_valid = 1'b1;
				if (res_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign res   = res_q;
	assign count = COUNT_W'(occ_q);

endmodule

// ----- hdl/sorted_nexthop_priority_list.sv -----
// Sorted next-hop list: holds up to DEPTH entries of a 32-bit address and a
// 16-bit preference in ascending preference order, an insert landing after
// every entry of equal preference. Each request on the slave stream carries
// one operation (insert, pop head, read at a 1-based position, membership
// test, clear) and gives exactly one result on the master stream, which
// always reports the entry count after the operation. The entries live in a
// single memory with a registered read, and a sequencer walks it one entry
// per cycle, so the time per request follows the occupancy n: an insert
// moves the larger entries up from the tail down to the insertion point, a
// pop shifts the rest up to the head and a membership test scans all n, while
// a read, a clear or an insert into an empty list does not walk the list.
// A new request is taken once the previous result has moved into the output
// register, so the list can work on the next request while the consumer has
// yet to take the last result; a result that still finds the output register
// occupied holds the sequencer in its final state and so stalls the input.
module sorted_nexthop_priority_list import snpl_pkg::*; #(
	parameter int DEPTH = SNPL_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// op[2:0], hop_address[34:3], preference[50:35], position[55:51]
	input  logic [55:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// result_address[31:0], result_preference[47:32], present[48],
	// entry_count[53:49], status[55:54]
	output logic [55:0] m_axis_tdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	req_t               req;
	res_t               res;
	logic [COUNT_W-1:0] count;
	logic               res_valid;
	logic               res_free;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [AW-1:0]      mem_raddr;
	entry_t             mem_wdata;
	entry_t             mem_rdata;
	logic               out_valid_q;
	logic [55:0]        out_data_q;

	// Unpack the request fields from the lowest bit up.
	assign req.op          = s_axis_tdata[2:0];
	assign req.hop_address = s_axis_tdata[34:3];
	assign req.preference  = s_axis_tdata[50:35];
	assign req.position    = s_axis_tdata[55:51];

	snpl_seq #(.DEPTH(DEPTH)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req       (req),
		.req_ready (s_axis_tready),
		.res_valid (res_valid),
		.res       (res),
		.count     (count),
		.res_free  (res_free),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	snpl_mem #(.DEPTH(DEPTH)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// The output register is free when empty or being emptied this cycle.
	assign res_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_free) begin
			out_data_q <= {res.status, count, res.present, res.pref, res.addr};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ----- hdl/snpl_chk.sv -----
module snpl_chk import snpl_pkg::*; #(
	parameter int DEPTH = SNPL_DEPTH
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata
);

	// A stalled result stays offered and unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed or was withdrawn");

	// A dropped insert is reported only when the list is full.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[55:54] == STAT_FULL)
		|-> m_axis_tdata[53:49] == COUNT_W'(DEPTH))
		else $error("full status with a count below the depth");

	// An empty report carries a zero count and no entry.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[55:54] == STAT_EMPTY)
		|-> (m_axis_tdata[53:49] == '0) && (m_axis_tdata[47:0] == '0))
		else $error("empty status with entries or data");

	// The count never exceeds the depth.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (DEPTH > 31) || (m_axis_tdata[53:49] <= COUNT_W'(DEPTH)))
		else $error("entry count above the depth");

	// The block takes no new request in the cycle after taking one.
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while the previous one is in progress");

endmodule

bind sorted_nexthop_priority_list snpl_chk #(.DEPTH(DEPTH)) u_snpl_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ----- dv/sorted_nexthop_priority_list_tb.sv -----
module sorted_nexthop_priority_list_tb import snpl_pkg::*;;

	localparam int LIST_DEPTH  = SNPL_DEPTH;
	localparam int ADDR_POOL   = 16;
	localparam int HOLD_CYCLES = 150;
	// Far beyond the slowest legal run: roughly 850 requests, each waiting out
	// sender gaps, receiver stalls and a shift across a full list.
	localparam int TIMEOUT     = 1600000;

	// One result as it appears on the master stream, unpacked.
	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [PREF_W-1:0]  pref;
		logic               present;
		logic [COUNT_W-1:0] count;
		status_t            status;
	} hop_result_t;

	// Tracks the list contents as each request is accepted and compares every
	// result, in order, against the outcome worked out for its request.
	class nexthop_list_scoreboard;
		logic [ADDR_W-1:0] held_addr[LIST_DEPTH];
		logic [PREF_W-1:0] held_pref[LIST_DEPTH];
		int                held_count   = 0;
		hop_result_t       pending_results[$];
		int                errors       = 0;
		int                checked      = 0;
		int                full_drops   = 0;
		int                empty_answers = 0;
		int                member_hits  = 0;
		int                tie_inserts  = 0;

		function int outstanding();
			return pending_results.size();
		endfunction

		// Works out the result of one accepted request and updates the list.
		function void note_request(logic [2:0] op, logic [ADDR_W-1:0] addr,
				logic [PREF_W-1:0] pref, logic [POS_W-1:0] pos);
			hop_result_t r;
			int slot;
			int idx;
			r = '{addr: '0, pref: '0, present: 1'b0, count: '0, status: STAT_OK};
			case (op)
				OP_INSERT: begin
					if (held_count >= LIST_DEPTH) begin
						r.status = STAT_FULL;
						full_drops++;
					end else begin
						// An equal preference goes behind the entries already held.
						slot = 0;
						while (slot < held_count && held_pref[slot] <= pref)
							slot++;
						if (slot > 0 && held_pref[slot-1] == pref)
							tie_inserts++;
						for (int k = held_count; k > slot; k--) begin
							held_addr[k] = held_addr[k-1];
							held_pref[k] = held_pref[k-1];
						end
						held_addr[slot] = addr;
						held_pref[slot] = pref;
						held_count++;
					end
				end
				OP_POP: begin
					if (held_count == 0) begin
						r.status = STAT_EMPTY;
						empty_answers++;
					end else begin
						r.addr = held_addr[0];
						r.pref = held_pref[0];
						for (int k = 1; k < held_count; k++) begin
							held_addr[k-1] = held_addr[k];
							held_pref[k-1] = held_pref[k];
						end
						held_count--;
					end
				end
				OP_READ: begin
					if (held_count == 0) begin
						r.status = STAT_EMPTY;
						empty_answers++;
					end else begin
						// Position zero means the head; beyond the tail means the tail.
						idx = int'(pos);
						if (idx < 1)
							idx = 1;
						if (idx > held_count)
							idx = held_count;
						r.addr = held_addr[idx-1];
						r.pref = held_pref[idx-1];
					end
				end
				OP_MEMBER: begin
					for (int k = 0; k < held_count; k++)
						if (held_addr[k] == addr)
							r.present = 1'b1;
					if (r.present)
						member_hits++;
				end
				OP_CLEAR: held_count = 0;
				default: ;
			endcase
			r.count = held_count[COUNT_W-1:0];
			pending_results.push_back(r);
		endfunction

		function void check_result(logic [55:0] beat);
			hop_result_t want;
			logic [ADDR_W-1:0]  got_addr;
			logic [PREF_W-1:0]  got_pref;
			logic               got_present;
			logic [COUNT_W-1:0] got_count;
			logic [1:0]         got_status;
			got_addr    = beat[31:0];
			got_pref    = beat[47:32];
			got_present = beat[48];
			got_count   = beat[53:49];
			got_status  = beat[55:54];
			checked++;
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding: %h", beat);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got_addr !== want.addr) begin
				$error("result_address: expected %h, got %h", want.addr, got_addr);
				errors++;
			end
			if (got_pref !== want.pref) begin
				$error("result_preference: expected %h, got %h", want.pref, got_pref);
				errors++;
			end
			if (got_present !== want.present) begin
				$error("present: expected %b, got %b", want.present, got_present);
				errors++;
			end
			if (got_count !== want.count) begin
				$error("entry_count: expected %0d, got %0d", want.count, got_count);
				errors++;
			end
			if (got_status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got_status);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// op[2:0], hop_address[34:3], preference[50:35], position[55:51]
	logic [55:0] s_axis_tdata  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// result_address[31:0], result_preference[47:32], present[48],
	// entry_count[53:49], status[55:54]
	logic [55:0] m_axis_tdata;

	nexthop_list_scoreboard sb = new();

	// Idling controls, set by the stimulus for each phase.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	// Bumping the token asks the receiver for one long hold-off.
	int hold_token     = 0;
	int hold_seen      = 0;
	int hold_left      = 0;
	int sent           = 0;

	logic [ADDR_W-1:0] recent_addr[ADDR_POOL];
	int                pool_next = 0;

	sorted_nexthop_priority_list #(
		.DEPTH(LIST_DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(TIMEOUT);
		$display("sorted_nexthop_priority_list_tb: done, errors");
		$finish;
	end

	// Receiver: stalls at random, or holds off entirely for a long stretch when
	// asked, which lets the block fill its output and push back on requests.
	always @(negedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	// Offers one request and returns at the falling edge after it is taken.
	// Entered at a falling edge, so valid is only ever driven once per step.
	task automatic send_request(input logic [2:0] op, input logic [ADDR_W-1:0] addr,
			input logic [PREF_W-1:0] pref, input logic [POS_W-1:0] pos);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {pos, pref, addr, op};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_request(op, addr, pref, pos);
		sent++;
		if (op == OP_INSERT) begin
			recent_addr[pool_next] = addr;
			pool_next = (pool_next + 1) % ADDR_POOL;
		end
		@(negedge clk);
	endtask

	// Stops offering until every request has produced its result.
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		while (sb.outstanding() != 0)
			@(negedge clk);
	endtask

	// One random request. Addresses are often reused from recent inserts so
	// that membership tests hit, and preferences often come from a narrow
	// range so that equal preferences pile up and stable ordering is exercised.
	task automatic issue_random_request(input int insert_pct, input int pop_pct);
		logic [2:0]        op;
		logic [ADDR_W-1:0] addr;
		logic [PREF_W-1:0] pref;
		logic [POS_W-1:0]  pos;
		int                pick;
		pick = $urandom_range(99);
		if (pick < insert_pct)
			op = OP_INSERT;
		else if (pick < insert_pct + pop_pct)
			op = OP_POP;
		else if (pick < 98)
			op = $urandom_range(1) ? OP_READ : OP_MEMBER;
		else
			op = OP_CLEAR;
		if ($urandom_range(1))
			addr = recent_addr[$urandom_range(ADDR_POOL-1)];
		else
			addr = $urandom;
		case ($urandom_range(9))
			0: pref = '0;
			1: pref = '1;
			2, 3, 4, 5: pref = PREF_W'($urandom_range(7));
			default: pref = PREF_W'($urandom);
		endcase
		pos = POS_W'($urandom_range(LIST_DEPTH));
		send_request(op, addr, pref, pos);
	endtask

	// A phase first leans towards inserts, so the list fills and overflows,
	// then towards pops, so it drains and runs empty.
	task automatic run_phase(input int send_pct, input int recv_pct, input int n);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		repeat (n)
			issue_random_request(70, 10);
		repeat (n)
			issue_random_request(20, 50);
		wait_for_results();
	endtask

	initial begin
		for (int i = 0; i < ADDR_POOL; i++)
			recent_addr[i] = $urandom;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: an empty list first, then ordering, ties and extremes.
		send_request(OP_POP,    32'h0,        16'h0,    5'd0);
		send_request(OP_READ,   32'h0,        16'h0,    5'd0);
		send_request(OP_MEMBER, 32'h0A000001, 16'h0,    5'd0);
		send_request(OP_INSERT, 32'h0A000001, 16'd100,  5'd0);
		send_request(OP_INSERT, 32'h0A000002, 16'd50,   5'd0);
		send_request(OP_INSERT, 32'h0A000003, 16'd100,  5'd0);
		send_request(OP_INSERT, 32'h00000000, 16'h0000, 5'd0);
		send_request(OP_INSERT, 32'hFFFFFFFF, 16'hFFFF, 5'd31);
		send_request(OP_READ,   32'h0,        16'h0,    5'd0);
		send_request(OP_READ,   32'h0,        16'h0,    5'd1);
		send_request(OP_READ,   32'h0,        16'h0,    5'd3);
		send_request(OP_READ,   32'h0,        16'h0,    5'd4);
		send_request(OP_READ,   32'h0,        16'h0,    5'd16);
		send_request(OP_MEMBER, 32'h0A000003, 16'h0,    5'd0);
		send_request(OP_MEMBER, 32'h00000000, 16'h0,    5'd0);
		send_request(OP_MEMBER, 32'hFFFFFFFF, 16'h0,    5'd0);
		send_request(OP_MEMBER, 32'h0A0000FF, 16'h0,    5'd0);
		send_request(OP_POP,    32'h0,        16'h0,    5'd0);
		send_request(OP_CLEAR,  32'h0,        16'h0,    5'd0);
		send_request(OP_READ,   32'h0,        16'h0,    5'd2);
		send_request(OP_MEMBER, 32'h0A000001, 16'h0,    5'd0);
		send_request(OP_POP,    32'h0,        16'h0,    5'd0);
		wait_for_results();

		// Back-pressure: the receiver holds off while requests keep coming, so
		// the block has to stall its input until the hold is lifted.
		hold_token++;
		repeat (15)
			issue_random_request(60, 15);
		wait_for_results();

		run_phase(0, 0, 100);
		run_phase(82, 0, 100);
		run_phase(0, 82, 100);
		run_phase(27, 27, 100);

		wait_for_results();
		repeat (60) @(negedge clk);

		$display("%0d requests sent, %0d results checked, %0d inserts refused on a full list",
			sent, sb.checked, sb.full_drops);
		$display("%0d pops or reads on an empty list, %0d membership hits, %0d tied inserts",
			sb.empty_answers, sb.member_hits, sb.tie_inserts);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("sorted_nexthop_priority_list_tb: done, clean");
		else
			$display("sorted_nexthop_priority_list_tb: done, errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/snpl_pkg.sv
hdl/snpl_mem.sv
hdl/snpl_seq.sv
hdl/sorted_nexthop_priority_list.sv
hdl/snpl_chk.sv
dv/sorted_nexthop_priority_list_tb.sv
